>>> rtl/core/pslex_pkg.sv
// ----------------------------------------------------------------------------
// Pascal subset lexer package
// Token classes, scanner kinds, character codes and the keyword and operator
// tables. The table text is packed with the first byte in the lowest bits.
// ----------------------------------------------------------------------------
package pslex_pkg;

  // Default parameter values
  localparam int MAX_LEN_DEFAULT   = 99;
  localparam int LINE_BITS_DEFAULT = 20;

  // Field widths
  localparam int CHAR_BITS    = 8;
  localparam int CLASS_BITS   = 5;
  localparam int OUT_LINE_BITS = 20;
  localparam int LEN_BITS     = 7;
  localparam int PREFIX_BYTES = 7;
  localparam int PREFIX_BITS  = PREFIX_BYTES * CHAR_BITS;
  localparam int NUM_KEYWORDS = 11;
  localparam int NUM_OPERATORS = 16;

  // Largest start line that the result field can show
  localparam logic [31:0] OUT_LINE_LIMIT = 32'h000F_FFFF;

  // Kind of the token that is being collected
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_IDENT  = 2'd1,
    KIND_NUMBER = 2'd2,
    KIND_OPER   = 2'd3
  } kind_t;

  // Token classes
  localparam logic [CLASS_BITS-1:0] CLASS_IDENT   = 5'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_INT     = 5'd12;
  localparam logic [CLASS_BITS-1:0] CLASS_REAL    = 5'd13;
  localparam logic [CLASS_BITS-1:0] CLASS_OP_BASE = 5'd14;
  localparam logic [CLASS_BITS-1:0] CLASS_UNKNOWN = 5'd30;
  localparam logic [CLASS_BITS-1:0] CLASS_EOF     = 5'd31;

  // Character codes
  localparam logic [CHAR_BITS-1:0] CHAR_DOT     = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_BITS-1:0] CHAR_CR      = 8'h0D;

  // Input kinds carried in tuser
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Keywords: program var begin end integer real if then else while do
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    56'h6d_61_72_67_6f_72_70,
    56'h72_61_76,
    56'h6e_69_67_65_62,
    56'h64_6e_65,
    56'h72_65_67_65_74_6e_69,
    56'h6c_61_65_72,
    56'h66_69,
    56'h6e_65_68_74,
    56'h65_73_6c_65,
    56'h65_6c_69_68_77,
    56'h6f_64
  };
  localparam logic [LEN_BITS-1:0] KW_LEN [NUM_KEYWORDS] = '{
    7'd7, 7'd3, 7'd5, 7'd3, 7'd7, 7'd4, 7'd2, 7'd4, 7'd4, 7'd5, 7'd2
  };

  // Operators: + - * / > < <= >= := = ; : , . ( )
  localparam logic [PREFIX_BITS-1:0] OP_TEXT [NUM_OPERATORS] = '{
    56'h2b, 56'h2d, 56'h2a, 56'h2f, 56'h3e, 56'h3c, 56'h3d_3c, 56'h3d_3e,
    56'h3d_3a, 56'h3d, 56'h3b, 56'h3a, 56'h2c, 56'h2e, 56'h28, 56'h29
  };
  localparam logic [LEN_BITS-1:0] OP_LEN [NUM_OPERATORS] = '{
    7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd2, 7'd2,
    7'd2, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1
  };

  // Character classes
  function automatic logic is_digit(logic [CHAR_BITS-1:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alpha(logic [CHAR_BITS-1:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_space(logic [CHAR_BITS-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Identifier class: a keyword when text and length match, else identifier.
  // Bytes past the token length are zero, so a full compare is exact.
  function automatic logic [CLASS_BITS-1:0] ident_class(logic [PREFIX_BITS-1:0] p,
                                                        logic [LEN_BITS-1:0] n);
    logic [CLASS_BITS-1:0] cls;
    cls = CLASS_IDENT;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if ((p == KW_TEXT[i]) && (n == KW_LEN[i])) begin
        cls = CLASS_BITS'(i + 1);
      end
    end
    return cls;
  endfunction

  // Operator run class: one of the operators, else unknown.
  function automatic logic [CLASS_BITS-1:0] oper_class(logic [PREFIX_BITS-1:0] p,
                                                       logic [LEN_BITS-1:0] n);
    logic [CLASS_BITS-1:0] cls;
    cls = CLASS_UNKNOWN;
    for (int i = 0; i < NUM_OPERATORS; i++) begin
      if ((p == OP_TEXT[i]) && (n == OP_LEN[i])) begin
        cls = CLASS_OP_BASE + CLASS_BITS'(i);
      end
    end
    return cls;
  endfunction

endpackage

>>> rtl/core/pascal_subset_lexer.sv
// ----------------------------------------------------------------------------
// Pascal subset lexer
// Groups a byte stream into identifier, keyword, number and operator tokens.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_*) carries one byte per transaction in s_tdata; s_tuser
// is 0 for a character and 1 for end of input. The output channel (m_*)
// carries one finished token per transaction: class, start line and length,
// with m_tlast set on the last token caused by an input transaction.
// A token appears on m_* in the cycle after the byte that ends it is
// accepted. Throughput: one byte per cycle while s_tready is high; the byte
// is classified and the token state updated in the same cycle, against the
// keyword and operator tables compared in parallel. End of input with an open
// token gives two results, so s_tready stays low while the second (EOF)
// result waits to move into the output register.
// Reset: no token is open and the line count is 1; the output is empty.
// Stall: while m_tready is low a result holds in the output register and
// s_tready stays low until it is taken.
// ----------------------------------------------------------------------------
module pascal_subset_lexer #(
  parameter int MAX_LEN   = pslex_pkg::MAX_LEN_DEFAULT,
  parameter int LINE_BITS = pslex_pkg::LINE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] func
  // Output channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] token_class, [24:5] start_line,
                                 // [31:25] token_length
  output logic        m_tlast    // last_of_run
);

  localparam int CB = pslex_pkg::CLASS_BITS;
  localparam int OB = pslex_pkg::OUT_LINE_BITS;
  localparam int LB = pslex_pkg::LEN_BITS;
  localparam int PB = pslex_pkg::PREFIX_BITS;
  localparam logic [LB-1:0] LEN_LIMIT = LB'(MAX_LEN);
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // Token state
  pslex_pkg::kind_t     open_kind, open_kind_next;
  logic [PB-1:0]        prefix_chars, prefix_chars_next;
  logic [LB-1:0]        open_length, open_length_next;
  logic                 seen_dot, seen_dot_next;
  logic                 prev_was_digit, prev_was_digit_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [LINE_BITS-1:0] open_line, open_line_next;

  // Output register and the pending second result
  logic          out_valid;
  logic [CB-1:0] out_class;
  logic [OB-1:0] out_line;
  logic [LB-1:0] out_len;
  logic          out_last;
  logic          pend_valid;
  logic [OB-1:0] pend_line;

  // Results of the accepted transaction
  logic          r0_valid;
  logic [CB-1:0] r0_class;
  logic [OB-1:0] r0_line;
  logic [LB-1:0] r0_len;
  logic          r0_last;
  logic          r1_valid;

  logic                     accept;
  logic [7:0]               c;
  logic                     c_digit, c_alpha, c_space;
  logic                     cont;
  logic [CB-1:0]            fin_class;
  logic [OB-1:0]            open_line_sat, line_count_sat;
  logic [31:0]              open_line_ext, line_count_ext;
  logic                     start_new;
  pslex_pkg::kind_t         new_kind;

  assign s_tready = !pend_valid && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign c_digit  = pslex_pkg::is_digit(c);
  assign c_alpha  = pslex_pkg::is_alpha(c);
  assign c_space  = pslex_pkg::is_space(c);

  // Class of the open token if it ends now
  always_comb begin
    unique case (open_kind)
      pslex_pkg::KIND_NUMBER: fin_class = seen_dot ? pslex_pkg::CLASS_REAL
                                                   : pslex_pkg::CLASS_INT;
      pslex_pkg::KIND_IDENT:  fin_class = pslex_pkg::ident_class(prefix_chars, open_length);
      default:                fin_class = pslex_pkg::oper_class(prefix_chars, open_length);
    endcase
  end

  // Line numbers clipped to the width of the result field
  always_comb begin
    open_line_ext  = 32'(open_line);
    line_count_ext = 32'(line_count);
    open_line_sat  = (open_line_ext > pslex_pkg::OUT_LINE_LIMIT) ?
                     pslex_pkg::OUT_LINE_LIMIT[OB-1:0] : open_line_ext[OB-1:0];
    line_count_sat = (line_count_ext > pslex_pkg::OUT_LINE_LIMIT) ?
                     pslex_pkg::OUT_LINE_LIMIT[OB-1:0] : line_count_ext[OB-1:0];
  end

  // Whether the byte extends the open token
  always_comb begin
    cont = 1'b0;
    if ((open_kind != pslex_pkg::KIND_NONE) && (open_length < LEN_LIMIT)) begin
      unique case (open_kind)
        pslex_pkg::KIND_IDENT:  cont = c_alpha || c_digit;
        pslex_pkg::KIND_NUMBER: cont = c_digit || ((c == pslex_pkg::CHAR_DOT) && prev_was_digit);
        default:                cont = !c_alpha && !c_digit && !c_space;
      endcase
    end
  end

  // Next token state and the results of one transaction
  always_comb begin
    open_kind_next      = open_kind;
    prefix_chars_next   = prefix_chars;
    open_length_next    = open_length;
    seen_dot_next       = seen_dot;
    prev_was_digit_next = prev_was_digit;
    line_count_next     = line_count;
    open_line_next      = open_line;
    r0_valid = 1'b0;
    r0_class = fin_class;
    r0_line  = open_line_sat;
    r0_len   = open_length;
    r0_last  = 1'b1;
    r1_valid = 1'b0;
    start_new = 1'b0;
    new_kind  = open_kind;

    if (s_tuser == pslex_pkg::FUNC_END) begin
      // End of input: flush the open token, then EOF; start a new stream.
      if (open_kind != pslex_pkg::KIND_NONE) begin
        r0_valid = 1'b1;
        r0_last  = 1'b0;
        r1_valid = 1'b1;
      end else begin
        r0_valid = 1'b1;
        r0_class = pslex_pkg::CLASS_EOF;
        r0_line  = line_count_sat;
        r0_len   = '0;
      end
      open_kind_next      = pslex_pkg::KIND_NONE;
      prefix_chars_next   = '0;
      open_length_next    = '0;
      seen_dot_next       = 1'b0;
      prev_was_digit_next = 1'b0;
      line_count_next     = LINE_ONE;
      open_line_next      = LINE_ONE;
    end else if (cont) begin
      new_kind  = open_kind;
      start_new = 1'b1;
    end else begin
      // The byte ends the open token and is scanned as a new start.
      if (open_kind != pslex_pkg::KIND_NONE) begin
        r0_valid = 1'b1;
      end
      open_kind_next      = pslex_pkg::KIND_NONE;
      prefix_chars_next   = '0;
      open_length_next    = '0;
      seen_dot_next       = 1'b0;
      prev_was_digit_next = 1'b0;
      if (c_space) begin
        if ((c == pslex_pkg::CHAR_NEWLINE) && (line_count != '1)) begin
          line_count_next = line_count + LINE_ONE;
        end
      end else begin
        new_kind       = c_alpha ? pslex_pkg::KIND_IDENT :
                         (c_digit ? pslex_pkg::KIND_NUMBER : pslex_pkg::KIND_OPER);
        open_line_next = line_count;
        start_new      = 1'b1;
      end
    end

    // Append the byte to the token, either continued or freshly opened.
    if (start_new) begin
      open_kind_next = new_kind;
      if (open_length_next < LB'(pslex_pkg::PREFIX_BYTES)) begin
        prefix_chars_next = prefix_chars_next |
                            (PB'(c) << (8 * open_length_next[2:0]));
      end
      open_length_next = open_length_next + LB'(1);
      if ((new_kind == pslex_pkg::KIND_NUMBER) && (c == pslex_pkg::CHAR_DOT)) begin
        seen_dot_next = 1'b1;
      end
      prev_was_digit_next = c_digit;
    end
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_kind      <= pslex_pkg::KIND_NONE;
      prefix_chars   <= '0;
      open_length    <= '0;
      seen_dot       <= 1'b0;
      prev_was_digit <= 1'b0;
      line_count     <= LINE_ONE;
      open_line      <= LINE_ONE;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      if (accept) begin
        open_kind      <= open_kind_next;
        prefix_chars   <= prefix_chars_next;
        open_length    <= open_length_next;
        seen_dot       <= seen_dot_next;
        prev_was_digit <= prev_was_digit_next;
        line_count     <= line_count_next;
        open_line      <= open_line_next;
        out_valid      <= r0_valid;
        out_class      <= r0_class;
        out_line       <= r0_line;
        out_len        <= r0_len;
        out_last       <= r0_last;
        pend_valid     <= r1_valid;
        pend_line      <= line_count_sat;
      end else if (out_valid && m_tready) begin
        // The EOF result that follows a flushed token moves up.
        if (pend_valid) begin
          out_class  <= pslex_pkg::CLASS_EOF;
          out_line   <= pend_line;
          out_len    <= '0;
          out_last   <= 1'b1;
          pend_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_line, out_class};
  assign m_tlast  = out_last;

endmodule
